### rtl/core/bsdd_pkg.sv
// Shared constants for the biphase symbol synchronizer and differential decoder.
package bsdd_pkg;

	// Configuration port layout.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_SYMBOL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACQUISITION_SYMBOLS = 2'd1;

	// Register widths and reset values.
	localparam int SPS_CFG_W = 6;
	localparam int ACQ_CFG_W = 10;
	localparam logic [SPS_CFG_W-1:0] SPS_RESET = 6'd16;
	localparam logic [ACQ_CFG_W-1:0] ACQ_RESET = 10'd300;

	// Smallest usable oversampling factor.
	localparam logic [SPS_CFG_W-1:0] SPS_MIN = 6'd2;

endpackage

### rtl/core/bsdd_if.sv
// Valid/ready channel interfaces for input samples and decoded bits.
interface bsdd_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface bsdd_bit_if;
	logic valid;
	logic ready;
	logic data_bit;

	modport source (output valid, output data_bit, input ready);
	modport sink (input valid, input data_bit, output ready);
endinterface

### rtl/core/biphase_symbol_sync_diff_decoder_top.sv
// Biphase symbol synchronizer with timing acquisition and differential decoder.
//
//   channel      dir  payload               beat
//   sample_chan  in   sample (signed)       one oversampled baseband sample
//   bit_chan     out  data_bit              one differentially decoded bit
//   cfg_*        in   cfg_index, cfg_data   one register write, no handshake
//
// For each sample one shared adder walks the window store
// one entry per cycle behind its registered read port. After a smaller factor is written,
// the next sample first takes the subtraction steps that bring the pointers in range.
// At the end of acquisition a lock pass walks the energy store for the strongest phase.
// The input is ready only between samples; a decoded bit waits in an output register, and
// the block stalls only if a second bit is due before it is taken. Reset is asynchronous.
module biphase_symbol_sync_diff_decoder_top #(
	parameter int MAX_SAMPLES_PER_SYMBOL = 32,
	parameter int SAMPLE_WIDTH           = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bsdd_sample_if.sink                    sample_chan,
	bsdd_bit_if.source                     bit_chan,
	input  logic                           cfg_we,
	input  logic [bsdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsdd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W    = $clog2(MAX_SAMPLES_PER_SYMBOL);
	localparam int SPS_W    = IDX_W + 1;
	localparam int CMP_W    = SPS_W + bsdd_pkg::SPS_CFG_W;
	localparam int CORR_W   = SAMPLE_WIDTH + SPS_W;
	localparam int ENERGY_W = CORR_W + bsdd_pkg::ACQ_CFG_W + SPS_W;
	localparam int CNT_W    = bsdd_pkg::ACQ_CFG_W + SPS_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CORR,
		ST_POST,
		ST_ARGMAX
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [bsdd_pkg::SPS_CFG_W-1:0] sps_cfg_q;
	logic [bsdd_pkg::ACQ_CFG_W-1:0] acq_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_cfg_q <= bsdd_pkg::SPS_RESET;
			acq_cfg_q <= bsdd_pkg::ACQ_RESET;
		end else if (cfg_we) begin
			if (cfg_index == bsdd_pkg::REG_SAMPLES_PER_SYMBOL) begin
				sps_cfg_q <= cfg_data[bsdd_pkg::SPS_CFG_W-1:0];
			end
			if (cfg_index == bsdd_pkg::REG_ACQUISITION_SYMBOLS) begin
				acq_cfg_q <= cfg_data[bsdd_pkg::ACQ_CFG_W-1:0];
			end
		end
	end

	// Oversampling factor clamped to the supported range.
	logic [SPS_W-1:0] sps_eff;

	always_comb begin
		priority if (sps_cfg_q < bsdd_pkg::SPS_MIN) begin
			sps_eff = SPS_W'(bsdd_pkg::SPS_MIN);
		end else if (CMP_W'(sps_cfg_q) > CMP_W'(MAX_SAMPLES_PER_SYMBOL)) begin
			sps_eff = SPS_W'(MAX_SAMPLES_PER_SYMBOL);
		end else begin
			sps_eff = SPS_W'(sps_cfg_q);
		end
	end

	// Sequencer registers.
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic [SPS_W-1:0]               sps_q;
	logic [SPS_W-1:0]               half_q;
	logic [IDX_W-1:0]               wi_q;
	logic [IDX_W-1:0]               ph_q;
	logic [IDX_W-1:0]               phase_cur_q;
	logic [IDX_W-1:0]               rd_ptr_q;
	logic [IDX_W-1:0]               k_q;
	logic                           issue_q;
	logic                           en_s1;
	logic                           neg_s1;
	logic                           last_s1;
	logic [IDX_W-1:0]               idx_s1;
	logic signed [CORR_W-1:0]       corr_q;
	logic [CNT_W-1:0]               acq_cnt_q;
	logic                           locked_q;
	logic [IDX_W-1:0]               chosen_q;
	logic [IDX_W-1:0]               best_q;
	logic [ENERGY_W-1:0]            best_val_q;
	logic                           prev_q;
	logic                           have_prev_q;
	logic                           out_valid_q;
	logic                           out_bit_q;

	// Store ports.
	logic                           win_we;
	logic                           win_re;
	logic signed [SAMPLE_WIDTH-1:0] win_rdata;
	logic                           e_we;
	logic                           e_re;
	logic [IDX_W-1:0]               e_raddr;
	logic [ENERGY_W-1:0]            e_wdata;
	logic [ENERGY_W-1:0]            e_rdata;

	// Index arithmetic: pointer reduction and wrapping increments.
	logic             wi_ge;
	logic             ph_ge;
	logic             reduce_done;
	logic [IDX_W-1:0] wi_inc;
	logic [IDX_W-1:0] ph_inc;
	logic [IDX_W-1:0] rd_inc;
	logic             k_last;

	assign wi_ge       = SPS_W'(wi_q) >= sps_q;
	assign ph_ge       = SPS_W'(ph_q) >= sps_q;
	assign reduce_done = (state_q == ST_REDUCE) && !wi_ge && !ph_ge;
	assign wi_inc      = (SPS_W'(wi_q) + SPS_W'(1) == sps_q) ? '0 : wi_q + IDX_W'(1);
	assign ph_inc      = (SPS_W'(ph_q) + SPS_W'(1) == sps_q) ? '0 : ph_q + IDX_W'(1);
	assign rd_inc      = (SPS_W'(rd_ptr_q) + SPS_W'(1) == sps_q) ? '0 : rd_ptr_q + IDX_W'(1);
	assign k_last      = SPS_W'(k_q) == sps_q - SPS_W'(1);

	// Post-correlation values: magnitude, slice, energy update and lock test.
	logic [CORR_W-1:0]  abs_corr;
	logic               slice;
	logic [CNT_W-1:0]   acq_next;
	logic [CNT_W-1:0]   acq_target;
	logic               phase_hit;
	logic               emit;
	logic               out_free;
	logic               better;

	assign abs_corr   = corr_q[CORR_W-1] ? CORR_W'(-corr_q) : CORR_W'(corr_q);
	assign slice      = !corr_q[CORR_W-1] && (corr_q != '0);
	assign acq_next   = acq_cnt_q + CNT_W'(1);
	assign acq_target = CNT_W'(acq_cfg_q) * CNT_W'(sps_q);
	assign e_wdata    = e_rdata + ENERGY_W'(abs_corr);
	assign phase_hit  = phase_cur_q == chosen_q;
	assign out_free   = !out_valid_q || bit_chan.ready;
	assign emit       = (state_q == ST_POST) && locked_q && phase_hit && have_prev_q && out_free;
	assign better     = e_rdata > best_val_q;

	assign win_we  = reduce_done;
	assign win_re  = (state_q == ST_CORR) && issue_q;
	assign e_we    = (state_q == ST_POST) && !locked_q;
	assign e_re    = reduce_done || ((state_q == ST_ARGMAX) && issue_q);
	assign e_raddr = reduce_done ? ph_q : k_q;

	// Window of recent samples.
	bsdd_store #(
		.DEPTH (MAX_SAMPLES_PER_SYMBOL),
		.WIDTH (SAMPLE_WIDTH)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (win_we),
		.waddr  (wi_q),
		.wdata  (sample_q),
		.re     (win_re),
		.raddr  (rd_ptr_q),
		.rdata  (win_rdata)
	);

	// Correlation energy per sample phase.
	bsdd_store #(
		.DEPTH (MAX_SAMPLES_PER_SYMBOL),
		.WIDTH (ENERGY_W)
	) u_energy (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (e_we),
		.waddr  (phase_cur_q),
		.wdata  (e_wdata),
		.re     (e_re),
		.raddr  (e_raddr),
		.rdata  (e_rdata)
	);

	// Sequencer: state, counters, accumulator and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sample_q    <= '0;
			sps_q       <= SPS_W'(bsdd_pkg::SPS_RESET);
			half_q      <= '0;
			wi_q        <= '0;
			ph_q        <= '0;
			phase_cur_q <= '0;
			rd_ptr_q    <= '0;
			k_q         <= '0;
			issue_q     <= 1'b0;
			en_s1       <= 1'b0;
			neg_s1      <= 1'b0;
			last_s1     <= 1'b0;
			idx_s1      <= '0;
			corr_q      <= '0;
			acq_cnt_q   <= '0;
			locked_q    <= 1'b0;
			chosen_q    <= '0;
			best_q      <= '0;
			best_val_q  <= '0;
			prev_q      <= 1'b0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_bit_q   <= 1'b0;
		end else begin
			// Output register drains independently of the sequencer.
			if (emit) begin
				out_valid_q <= 1'b1;
				out_bit_q   <= slice ^ prev_q;
			end else if (bit_chan.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (sample_chan.valid) begin
						sample_q <= sample_chan.sample;
						sps_q    <= sps_eff;
						half_q   <= sps_eff >> 1;
						state_q  <= ST_REDUCE;
					end
				end

				// Bring the pointers below the current factor, then store the sample.
				ST_REDUCE: begin
					if (wi_ge) begin
						wi_q <= IDX_W'(SPS_W'(wi_q) - sps_q);
					end
					if (ph_ge) begin
						ph_q <= IDX_W'(SPS_W'(ph_q) - sps_q);
					end
					if (reduce_done) begin
						wi_q        <= wi_inc;
						rd_ptr_q    <= wi_inc;
						phase_cur_q <= ph_q;
						ph_q        <= ph_inc;
						k_q         <= '0;
						issue_q     <= 1'b1;
						en_s1       <= 1'b0;
						corr_q      <= '0;
						state_q     <= ST_CORR;
					end
				end

				// Walk the window from oldest to newest; older half adds, newer subtracts.
				ST_CORR: begin
					en_s1 <= issue_q;
					if (issue_q) begin
						neg_s1   <= SPS_W'(k_q) >= half_q;
						last_s1  <= k_last;
						k_q      <= k_q + IDX_W'(1);
						rd_ptr_q <= rd_inc;
						issue_q  <= !k_last;
					end
					if (en_s1) begin
						corr_q <= neg_s1 ? corr_q - CORR_W'(win_rdata)
						                 : corr_q + CORR_W'(win_rdata);
						if (last_s1) begin
							state_q <= ST_POST;
						end
					end
				end

				// Acquire energy, or slice and decode at the locked phase.
				ST_POST: begin
					if (!locked_q) begin
						acq_cnt_q <= acq_next;
						if (acq_next >= acq_target) begin
							k_q        <= '0;
							issue_q    <= 1'b1;
							en_s1      <= 1'b0;
							best_q     <= '0;
							best_val_q <= '0;
							state_q    <= ST_ARGMAX;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (!phase_hit) begin
						state_q <= ST_IDLE;
					end else if (!have_prev_q || out_free) begin
						prev_q      <= slice;
						have_prev_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end

				// Pick the phase with the largest energy; ties keep the lower phase.
				ST_ARGMAX: begin
					en_s1 <= issue_q;
					if (issue_q) begin
						idx_s1  <= k_q;
						last_s1 <= k_last;
						k_q     <= k_q + IDX_W'(1);
						issue_q <= !k_last;
					end
					if (en_s1) begin
						if (better) begin
							best_q     <= idx_s1;
							best_val_q <= e_rdata;
						end
						if (last_s1) begin
							chosen_q <= better ? idx_s1 : best_q;
							locked_q <= 1'b1;
							state_q  <= ST_IDLE;
						end
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample_chan.ready = state_q == ST_IDLE;
	assign bit_chan.valid    = out_valid_q;
	assign bit_chan.data_bit = out_bit_q;

	// Timing lock, once taken, is kept until reset.
	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |=> locked_q)
		else $error("timing lock was dropped");

	// Decoded bits appear only after timing lock.
	a_emit_locked: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> locked_q && have_prev_q)
		else $error("bit emitted before lock or first slice");

	// Energies stop changing once locked.
	a_energy_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |-> !e_we)
		else $error("energy written after lock");

	// The window walk only addresses entries below the oversampling factor.
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		win_re |-> (SPS_W'(rd_ptr_q) < sps_q) && (SPS_W'(k_q) < sps_q))
		else $error("window walk out of range");

	// A pending bit is never overwritten by a new one.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !bit_chan.ready) |-> !emit)
		else $error("output register overrun");

endmodule

### rtl/core/bsdd_store.sv
// Single-port-read store with per-entry valid bits; unwritten entries read as zero.
module bsdd_store #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;

	// Valid bits are cleared by reset and set on the first write of each entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// Array write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= vld_q[raddr] ? mem[raddr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

### tb/tb.sv
// Testbench for the biphase symbol synchronizer and differential decoder.

// Scoreboard: tracks the synchronizer state and holds the decoded bits still due.
class bit_scoreboard;
	localparam int MAX_SPS = 32;

	bit [bsdd_pkg::SPS_CFG_W-1:0] sps_cfg;
	bit [bsdd_pkg::ACQ_CFG_W-1:0] acq_cfg;
	logic signed [15:0] window [MAX_SPS];
	longint unsigned    energy [MAX_SPS];
	int unsigned        wr_ptr;
	int unsigned        phase_cnt;
	longint unsigned    acq_cnt;
	bit                 locked;
	int unsigned        lock_phase;
	bit                 last_slice;
	bit                 have_last;
	bit                 due_bits [$];
	int                 fail_count;

	function new();
		sps_cfg    = bsdd_pkg::SPS_RESET;
		acq_cfg    = bsdd_pkg::ACQ_RESET;
		wr_ptr     = 0;
		phase_cnt  = 0;
		acq_cnt    = 0;
		locked     = 1'b0;
		lock_phase = 0;
		last_slice = 1'b0;
		have_last  = 1'b0;
		fail_count = 0;
		for (int i = 0; i < MAX_SPS; i++) begin
			window[i] = '0;
			energy[i] = 0;
		end
	endfunction

	function void write_reg(logic [bsdd_pkg::CFG_IDX_W-1:0] idx,
		logic [bsdd_pkg::CFG_DATA_W-1:0] data);
		if (idx == bsdd_pkg::REG_SAMPLES_PER_SYMBOL)
			sps_cfg = data[bsdd_pkg::SPS_CFG_W-1:0];
		else if (idx == bsdd_pkg::REG_ACQUISITION_SYMBOLS)
			acq_cfg = data[bsdd_pkg::ACQ_CFG_W-1:0];
	endfunction

	function int unsigned eff_sps();
		if (sps_cfg < bsdd_pkg::SPS_MIN)
			return 32'(bsdd_pkg::SPS_MIN);
		if (sps_cfg > MAX_SPS)
			return MAX_SPS;
		return 32'(sps_cfg);
	endfunction

	// Accepted sample: update the window, the timing search and the decoder.
	function void note_sample(logic signed [15:0] x);
		int unsigned     s;
		int unsigned     half;
		int unsigned     w;
		int unsigned     idx;
		int unsigned     phase;
		int unsigned     best;
		longint          corr;
		longint          mag;
		longint unsigned target;
		bit              slice;
		s    = eff_sps();
		half = s / 2;
		w    = wr_ptr % s;
		window[w] = x;
		wr_ptr = (w + 1 == s) ? 0 : w + 1;

		// Biphase kernel: older half counts plus, newer half minus.
		corr = 0;
		for (int unsigned k = 0; k < s; k++) begin
			idx = (wr_ptr + k) % s;
			if (k < half)
				corr += window[idx];
			else
				corr -= window[idx];
		end

		phase = phase_cnt % s;
		phase_cnt = (phase + 1 == s) ? 0 : phase + 1;

		// Acquisition: gather energy per phase, then lock on the strongest one.
		if (!locked) begin
			mag = (corr < 0) ? -corr : corr;
			energy[phase] += longint'(mag);
			acq_cnt++;
			target = acq_cfg * s;
			if (acq_cnt >= target) begin
				best = 0;
				for (int unsigned p = 1; p < s; p++)
					if (energy[p] > energy[best])
						best = p;
				lock_phase = best;
				locked = 1'b1;
			end
			return;
		end

		if (phase != lock_phase)
			return;

		// Slice and decode differentially; the first slice only primes the decoder.
		slice = (corr > 0);
		if (have_last)
			due_bits.insert(due_bits.size(), slice ^ last_slice);
		last_slice = slice;
		have_last = 1'b1;
	endfunction

	function void check_bit(logic data_bit);
		bit want;
		if (due_bits.size() == 0) begin
			$error("data_bit: no bit expected, actual %0b", data_bit);
			fail_count++;
			return;
		end
		want = due_bits.pop_front();
		if (data_bit !== want) begin
			$error("data_bit mismatch: expected %0b, actual %0b", want, data_bit);
			fail_count++;
		end
	endfunction

	function int pending();
		return due_bits.size();
	endfunction
endclass

module tb;
	localparam int SETTLE_CYCLES = 120;
	localparam int DRAIN_CYCLES  = 150;
	localparam int IDLE_LIMIT    = 4000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [bsdd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bsdd_pkg::CFG_DATA_W-1:0] cfg_data;

	bsdd_sample_if #(.SAMPLE_WIDTH(16)) sample_chan ();
	bsdd_bit_if bit_chan ();

	biphase_symbol_sync_diff_decoder_top #(
		.MAX_SAMPLES_PER_SYMBOL(32),
		.SAMPLE_WIDTH(16)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_chan(sample_chan),
		.bit_chan(bit_chan),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bit_scoreboard sb = new();

	int src_gap_pct;
	int snk_stall_pct;
	int stall_left;
	int idle_cycles;
	int items_sent;
	int sym_pos;
	int sym_amp;
	bit sym_bit;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Random gap length: mostly short, now and then long.
	function automatic int pick_gap(int pct);
		if (pct == 0 || $urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// Bit sink: check each accepted beat, then pick the next ready value.
	always @(posedge clk) begin
		if (!arst_n) begin
			bit_chan.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (bit_chan.valid && bit_chan.ready)
				sb.check_bit(bit_chan.data_bit);
			if (stall_left > 0) begin
				stall_left--;
				bit_chan.ready <= 1'b0;
			end else begin
				stall_left = pick_gap(snk_stall_pct);
				bit_chan.ready <= (stall_left == 0);
			end
		end
	end

	// Watchdog on cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (sample_chan.valid && sample_chan.ready) ||
			(bit_chan.valid && bit_chan.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Present one sample after a random gap and wait for its beat.
	task automatic send_sample(input logic signed [15:0] value);
		int gap;
		gap = pick_gap(src_gap_pct);
		if (gap > 0) begin
			sample_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_chan.valid  <= 1'b1;
		sample_chan.sample <= value;
		do
			@(posedge clk);
		while (!sample_chan.ready);
		sb.note_sample(value);
		items_sent++;
	endtask

	// Hold the sender off until every due bit has arrived.
	task automatic drain_bits();
		sample_chan.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Drain, then let a silent sample and a lock pass finish before a register write.
	task automatic settle();
		drain_bits();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bsdd_pkg::CFG_IDX_W-1:0] idx,
		input int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[bsdd_pkg::CFG_DATA_W-1:0];
		@(posedge clk);
		sb.write_reg(idx, value[bsdd_pkg::CFG_DATA_W-1:0]);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Next random sample: mostly biphase symbols with noise, the rest noise and extremes.
	function automatic logic signed [15:0] next_sample();
		int s;
		int v;
		int r;
		s = sb.eff_sps();
		if (sym_pos >= s)
			sym_pos = 0;
		if (sym_pos == 0) begin
			sym_bit = 1'($urandom_range(0, 1));
			sym_amp = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
				: $urandom_range(200, 12000);
		end
		v = (sym_pos < s / 2) ? sym_amp : -sym_amp;
		if (sym_bit)
			v = -v;
		v += $signed($urandom_range(0, 800)) - 400;
		sym_pos++;
		// A dropped sample now and then breaks the symbol alignment.
		if ($urandom_range(0, 49) == 0)
			sym_pos++;
		r = $urandom_range(0, 99);
		if (r >= 94)
			v = $urandom_range(0, 1) ? 32767 : -32768;
		else if (r >= 88)
			v = $signed($urandom_range(0, 6)) - 3;
		else if (r >= 75)
			v = $signed({16'h0, 16'($urandom())}) - 32768;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	initial begin
		int unsigned sps_list [16];
		int unsigned s_pick;
		int          n_items;
		int          phase_idx;
		int          pct_opts [4];

		sps_list = '{32, 63, 5, 33, 7, 3, 16, 9, 4, 12, 6, 40, 8, 24, 3, 10};
		pct_opts = '{0, 10, 30, 60};
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= '0;
		cfg_data           <= '0;
		sample_chan.valid  <= 1'b0;
		sample_chan.sample <= '0;
		src_gap_pct   = 0;
		snk_stall_pct = 0;
		items_sent    = 0;
		sym_pos       = 0;
		sym_amp       = 0;
		sym_bit       = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start acquiring at the largest window and the longest acquisition.
		write_reg(bsdd_pkg::REG_SAMPLES_PER_SYMBOL, 32);
		write_reg(bsdd_pkg::REG_ACQUISITION_SYMBOLS, 1023);
		send_sample(16'sd0);
		send_sample(16'sd0);

		// Shrink the window mid-run, then drop the target to zero so the next
		// sample locks; phases two and three tie and the lower one wins.
		settle();
		write_reg(bsdd_pkg::REG_SAMPLES_PER_SYMBOL, 4);
		send_sample(-16'sd32768);
		settle();
		write_reg(bsdd_pkg::REG_ACQUISITION_SYMBOLS, 0);
		send_sample(16'sd0);

		// Locked at S = 4: extremes and sign edges of the sample.
		send_sample(16'sd32767);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(-16'sd32768);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sd0);
		send_sample(16'sd0);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		for (int i = 0; i < 4; i++)
			send_sample(next_sample());

		// Odd window, with the locked phase still inside it.
		settle();
		write_reg(bsdd_pkg::REG_SAMPLES_PER_SYMBOL, 3);
		write_reg(bsdd_pkg::REG_ACQUISITION_SYMBOLS, 1);
		for (int i = 0; i < 7; i++)
			send_sample(next_sample());

		// Random part: a run of window settings with random idling on both sides.
		phase_idx = 0;
		while (items_sent < 780) begin
			settle();
			s_pick = sps_list[phase_idx % 16];
			write_reg(bsdd_pkg::REG_SAMPLES_PER_SYMBOL, s_pick);
			write_reg(bsdd_pkg::REG_ACQUISITION_SYMBOLS,
				($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(0, 1023));
			src_gap_pct   = (phase_idx == 0) ? 0 : pct_opts[$urandom_range(0, 3)];
			snk_stall_pct = (phase_idx == 0) ? 0 : pct_opts[$urandom_range(0, 3)];
			n_items = (sb.eff_sps() > 16) ? 90 : 45;
			for (int i = 0; i < n_items; i++) begin
				if (i == n_items / 2)
					drain_bits();
				send_sample(next_sample());
			end
			phase_idx++;
		end

		// Smallest windows and factors below the range; a locked phase beyond the
		// window keeps the decoder silent.
		src_gap_pct   = 10;
		snk_stall_pct = 10;
		settle();
		write_reg(bsdd_pkg::REG_SAMPLES_PER_SYMBOL, 2);
		for (int i = 0; i < 30; i++)
			send_sample(next_sample());
		settle();
		write_reg(bsdd_pkg::REG_SAMPLES_PER_SYMBOL, 1);
		for (int i = 0; i < 20; i++)
			send_sample(next_sample());
		settle();
		write_reg(bsdd_pkg::REG_SAMPLES_PER_SYMBOL, 0);
		for (int i = 0; i < 20; i++)
			send_sample(next_sample());

		// Wind down: wait for every due bit, then for the block to go quiet.
		drain_bits();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
